FILE: sv/rbb_pkg.sv
// Shared types, codes and constants for the LED blink / breathe pattern generator.
// Holds the mode and register index codes, the reset values and the breathe wave table.
// No dependencies.
package rbb_pkg;

  localparam int TIME_W_DEF  = 32;
  localparam int NOW_W       = 32;
  localparam int LEVEL_W     = 8;
  localparam int PERIOD_W    = 16;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PHASE_W     = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAST    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREATHE = 2'd3;

  localparam logic [PERIOD_W-1:0] FAST_RST    = 16'd300;
  localparam logic [PERIOD_W-1:0] SLOW_RST    = 16'd800;
  localparam logic [PERIOD_W-1:0] BREATHE_RST = 16'd40;

  localparam logic [LEVEL_W-1:0] LEVEL_DARK = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  // One result word handed from the front end to the output queue.
  typedef struct packed {
    logic               vld;
    logic [LEVEL_W-1:0] level;
  } push_t;

  // Sine brightness table, one full period over 64 steps.
  function automatic logic [LEVEL_W-1:0] wave_level(input logic [PHASE_W-1:0] idx);
    logic [LEVEL_W-1:0] lv;
    case (idx)
      6'd0:  lv = 8'd128;  6'd1:  lv = 8'd140;  6'd2:  lv = 8'd153;  6'd3:  lv = 8'd165;
      6'd4:  lv = 8'd177;  6'd5:  lv = 8'd188;  6'd6:  lv = 8'd199;  6'd7:  lv = 8'd209;
      6'd8:  lv = 8'd218;  6'd9:  lv = 8'd226;  6'd10: lv = 8'd234;  6'd11: lv = 8'd240;
      6'd12: lv = 8'd245;  6'd13: lv = 8'd250;  6'd14: lv = 8'd253;  6'd15: lv = 8'd254;
      6'd16: lv = 8'd254;  6'd17: lv = 8'd253;  6'd18: lv = 8'd250;  6'd19: lv = 8'd245;
      6'd20: lv = 8'd240;  6'd21: lv = 8'd234;  6'd22: lv = 8'd226;  6'd23: lv = 8'd218;
      6'd24: lv = 8'd209;  6'd25: lv = 8'd199;  6'd26: lv = 8'd188;  6'd27: lv = 8'd177;
      6'd28: lv = 8'd165;  6'd29: lv = 8'd153;  6'd30: lv = 8'd140;  6'd31: lv = 8'd128;
      6'd32: lv = 8'd128;  6'd33: lv = 8'd116;  6'd34: lv = 8'd103;  6'd35: lv = 8'd91;
      6'd36: lv = 8'd79;   6'd37: lv = 8'd68;   6'd38: lv = 8'd57;   6'd39: lv = 8'd47;
      6'd40: lv = 8'd38;   6'd41: lv = 8'd30;   6'd42: lv = 8'd22;   6'd43: lv = 8'd16;
      6'd44: lv = 8'd11;   6'd45: lv = 8'd6;    6'd46: lv = 8'd3;    6'd47: lv = 8'd2;
      6'd48: lv = 8'd2;    6'd49: lv = 8'd3;    6'd50: lv = 8'd6;    6'd51: lv = 8'd11;
      6'd52: lv = 8'd16;   6'd53: lv = 8'd22;   6'd54: lv = 8'd30;   6'd55: lv = 8'd38;
      6'd56: lv = 8'd47;   6'd57: lv = 8'd57;   6'd58: lv = 8'd68;   6'd59: lv = 8'd79;
      6'd60: lv = 8'd91;   6'd61: lv = 8'd103;  6'd62: lv = 8'd116;  6'd63: lv = 8'd128;
      default: lv = 8'd128;
    endcase
    return lv;
  endfunction

endpackage

FILE: sv/rbb_front.sv
// Front end: configuration registers, tick acceptance and pattern decision.
// Holds the last change time and the shared phase; pushes result words to the queue.
// Depends on rbb_pkg.
module rbb_front #(
  parameter int TIME_WIDTH = rbb_pkg::TIME_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbb_pkg::NOW_W-1:0]           in_now_ms,
  input  logic                                q_full,
  output rbb_pkg::push_t                      push
);
  import rbb_pkg::*;

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [PERIOD_W-1:0]   fast_r, fast_nxt;
  logic [PERIOD_W-1:0]   slow_r, slow_nxt;
  logic [PERIOD_W-1:0]   breathe_r, breathe_nxt;
  logic [TIME_WIDTH-1:0] last_change_r, last_change_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;

  logic                  tick_acc;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [PERIOD_W-1:0]   interval;
  logic                  timed;
  logic                  step;
  logic                  emit;
  logic [LEVEL_W-1:0]    level;
  logic                  mode_wr;

  assign in_stall = q_full;
  assign tick_acc = in_valid & ~q_full;
  assign now      = in_now_ms[TIME_WIDTH-1:0];
  assign elapsed  = now - last_change_r;
  assign mode_wr  = cfg_we && (cfg_index == REG_MODE);

  always_comb begin
    timed    = 1'b0;
    emit     = 1'b0;
    level    = LEVEL_DARK;
    interval = breathe_r;
    case (mode_r)
      MODE_OFF: begin
        emit  = 1'b1;
        level = LEVEL_DARK;
      end
      MODE_ON: begin
        emit  = 1'b1;
        level = LEVEL_FULL;
      end
      MODE_SLOW: begin
        timed    = 1'b1;
        interval = slow_r;
        level    = phase_r[0] ? LEVEL_DARK : LEVEL_FULL;
      end
      MODE_FAST: begin
        timed    = 1'b1;
        interval = fast_r;
        level    = phase_r[0] ? LEVEL_DARK : LEVEL_FULL;
      end
      MODE_BREATHE: begin
        timed    = 1'b1;
        interval = breathe_r;
        level    = wave_level(phase_r);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    step = timed && (elapsed >= TIME_WIDTH'(interval));
    if (step) begin
      emit = 1'b1;
    end
  end

  assign push.vld   = tick_acc && emit;
  assign push.level = level;

  always_comb begin
    mode_nxt        = mode_r;
    fast_nxt        = fast_r;
    slow_nxt        = slow_r;
    breathe_nxt     = breathe_r;
    last_change_nxt = last_change_r;
    phase_nxt       = phase_r;
    if (tick_acc && step) begin
      last_change_nxt = now;
      phase_nxt       = phase_r + 1'b1;
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE: begin
          mode_nxt        = cfg_wdata[MODE_W-1:0];
          last_change_nxt = '0;
        end
        REG_FAST: begin
          if (cfg_wdata != '0) fast_nxt = cfg_wdata[PERIOD_W-1:0];
        end
        REG_SLOW: begin
          if (cfg_wdata != '0) slow_nxt = cfg_wdata[PERIOD_W-1:0];
        end
        REG_BREATHE: begin
          if (cfg_wdata != '0) breathe_nxt = cfg_wdata[PERIOD_W-1:0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_OFF;
      fast_r        <= FAST_RST;
      slow_r        <= SLOW_RST;
      breathe_r     <= BREATHE_RST;
      last_change_r <= '0;
      phase_r       <= '0;
    end else begin
      mode_r        <= mode_nxt;
      fast_r        <= fast_nxt;
      slow_r        <= slow_nxt;
      breathe_r     <= breathe_nxt;
      last_change_r <= last_change_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // An accepted timed step always advances the phase by exactly one.
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && step) |=> (phase_r == $past(phase_r) + 1'b1))
    else $error("phase did not advance on a pattern step");

  a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mode_wr |=> (last_change_r == '0))
    else $error("mode write did not clear the change time");

  a_push_acc: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> (in_valid && !q_full))
    else $error("word pushed without an accepted tick");

endmodule

FILE: sv/rbb_queue.sv
// Output queue: a short FIFO of brightness words between the front end and the result port.
// The head entry drives the result channel directly, so a stalled word holds still.
// Depends on rbb_pkg.
module rbb_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbb_pkg::push_t                push,
  output logic                          q_full,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbb_pkg::LEVEL_W-1:0]   out_brightness
);
  import rbb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [LEVEL_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign q_full         = (count_r == CNT_W'(QUEUE_DEPTH));
  assign out_valid      = (count_r != '0);
  assign out_brightness = mem_r[rd_ptr_r];
  assign pop            = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.vld && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.vld && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !q_full)
    else $error("push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  // The fill count follows the pointers.
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

FILE: sv/rgb_blink_breathe_pattern.sv
// Top level of the LED blink / breathe pattern generator.
// Instantiates the front end (rbb_front) and the output queue (rbb_queue); uses rbb_pkg.
//
//   channel  ports                                 carries
//   in       in_valid, in_stall, in_now_ms         one tick with the millisecond time
//   out      out_valid, out_stall, out_brightness  one brightness word
//   cfg      cfg_we, cfg_index, cfg_wdata          register write, no read-back
//
// A tick is decided in the cycle it is accepted and its word, if any, is registered into the
// output queue behind any older words; one tick per cycle is sustained while the queue has room.
// The four-entry output queue sets how far the result side may stall before in_stall rises.
// Reset is synchronous on rst_n and empties the queue; there is no clearing pass.
module rgb_blink_breathe_pattern #(
  parameter int TIME_WIDTH = rbb_pkg::TIME_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rbb_pkg::NOW_W-1:0]      in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbb_pkg::LEVEL_W-1:0]    out_brightness
);
  import rbb_pkg::*;

  push_t push;
  logic  q_full;

  rbb_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_now_ms (in_now_ms),
    .q_full    (q_full),
    .push      (push)
  );

  rbb_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .q_full         (q_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_brightness (out_brightness)
  );

endmodule
